### hw/rtl/asl_pkg.sv
// Package for the audio soft limiter: register codes, widths, reset values and
// the control struct that travels with each sample down the divider chain.
// No dependencies.
package asl_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int DATA_BITS       = 32;
    localparam int FS_BITS         = 32;
    localparam int THR_BITS        = 31;
    localparam int K_BITS          = 62;
    localparam int Q_BITS          = 32;
    localparam int CFG_IDX_BITS    = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_FULL_SCALE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = CFG_IDX_BITS'(1);

    localparam logic [FS_BITS-1:0]  FS_RESET  = FS_BITS'(32768);
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(24576);

    typedef struct packed {
        logic neg;
        logic bypass;
    } asl_ctl_t;

endpackage

### hw/rtl/asl_front.sv
// Front end of the soft limiter: configuration registers, limiting constant K
// and the input stage (magnitude, sign, threshold compare). Uses asl_pkg.
module asl_front import asl_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [DATA_BITS-1:0]    in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_BITS-1:0]  out_mag,
    output asl_ctl_t                out_ctl,
    output logic [FS_BITS-1:0]      full_scale,
    output logic [K_BITS-1:0]       k_const
);

    logic [FS_BITS-1:0]     fs_reg;
    logic [THR_BITS-1:0]    thr_reg;
    logic [K_BITS-1:0]      k_reg;
    logic [K_BITS-1:0]      k_next;
    logic [FS_BITS-1:0]     diff;
    logic [K_BITS:0]        prod;
    logic                   v_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    asl_ctl_t               ctl_reg;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   neg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg  <= FS_RESET;
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FULL_SCALE: fs_reg  <= cfg_data;
                REG_THRESHOLD:  thr_reg <= cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // K = thr * (fs - thr), zero when the threshold reaches full scale
    assign diff = fs_reg - FS_BITS'(thr_reg);
    assign prod = thr_reg * diff;
    assign k_next = (FS_BITS'(thr_reg) < fs_reg) ? prod[K_BITS-1:0] : '0;

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
    end

    assign smp = in_data[SAMPLE_BITS-1:0];
    assign neg = smp[SAMPLE_BITS-1];
    assign mag = neg ? (~smp + SAMPLE_BITS'(1)) : smp;

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mag_reg        <= mag;
            ctl_reg.neg    <= neg;
            ctl_reg.bypass <= (FS_BITS'(mag) <= FS_BITS'(thr_reg));
        end
    end

    assign out_valid  = v_reg;
    assign out_mag    = mag_reg;
    assign out_ctl    = ctl_reg;
    assign full_scale = fs_reg;
    assign k_const    = k_reg;

endmodule

### hw/rtl/asl_div_cell.sv
// One cell of the restoring divider chain: takes one dividend bit of K,
// develops one quotient bit and hands remainder and quotient on. Uses asl_pkg.
module asl_div_cell import asl_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   k_bit,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_rem,
    input  logic [Q_BITS-1:0]      in_quo,
    input  logic [SAMPLE_BITS-1:0] in_mag,
    input  asl_ctl_t               in_ctl,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_rem,
    output logic [Q_BITS-1:0]      out_quo,
    output logic [SAMPLE_BITS-1:0] out_mag,
    output asl_ctl_t               out_ctl
);

    logic                   v_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [Q_BITS-1:0]      quo_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    asl_ctl_t               ctl_reg;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   ge;
    logic [SAMPLE_BITS-1:0] rem_next;

    assign trial    = {in_rem, k_bit};
    assign diff     = trial - {1'b0, in_mag};
    assign ge       = trial >= {1'b0, in_mag};
    assign rem_next = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg <= rem_next;
            quo_reg <= {in_quo[Q_BITS-2:0], ge};
            mag_reg <= in_mag;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_mag   = mag_reg;
    assign out_ctl   = ctl_reg;

endmodule

### hw/rtl/asl_finish.sv
// Back end of the soft limiter: ceiling of the quotient, subtraction from full
// scale, clip to sample range or bypass, sign; holds the output register. Uses asl_pkg.
module asl_finish import asl_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [FS_BITS-1:0]     full_scale,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_rem,
    input  logic [Q_BITS-1:0]      in_quo,
    input  logic [SAMPLE_BITS-1:0] in_mag,
    input  asl_ctl_t               in_ctl,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DATA_BITS-1:0]   out_data
);

    localparam logic [FS_BITS-1:0] POS_MAX = FS_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [FS_BITS-1:0] NEG_MAX = FS_BITS'(64'd1 << (SAMPLE_BITS - 1));

    logic                   a_v_reg;
    logic                   a_ready;
    logic [Q_BITS:0]        qc_reg;
    logic [SAMPLE_BITS-1:0] a_mag_reg;
    asl_ctl_t               a_ctl_reg;
    logic                   b_v_reg;
    logic [DATA_BITS-1:0]   data_reg;
    logic [FS_BITS-1:0]     r;
    logic [FS_BITS-1:0]     lim;
    logic [FS_BITS-1:0]     clip;
    logic [SAMPLE_BITS-1:0] m;
    logic [SAMPLE_BITS-1:0] res;

    assign a_ready  = !b_v_reg || out_ready;
    assign in_ready = !a_v_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_v_reg <= in_valid;
            end
            if (a_ready) begin
                b_v_reg <= a_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            qc_reg    <= {1'b0, in_quo} + (Q_BITS + 1)'(in_rem != '0);
            a_mag_reg <= in_mag;
            a_ctl_reg <= in_ctl;
        end
    end

    assign r    = (qc_reg <= {1'b0, full_scale}) ? (full_scale - qc_reg[FS_BITS-1:0]) : '0;
    assign lim  = a_ctl_reg.neg ? NEG_MAX : POS_MAX;
    assign clip = (r > lim) ? lim : r;
    assign m    = a_ctl_reg.bypass ? a_mag_reg : clip[SAMPLE_BITS-1:0];
    assign res  = a_ctl_reg.neg ? (~m + SAMPLE_BITS'(1)) : m;

    always_ff @(posedge aclk) begin
        if (a_v_reg && a_ready) begin
            data_reg <= DATA_BITS'($signed(res));
        end
    end

    assign out_valid = b_v_reg;
    assign out_data  = data_reg;

endmodule

### hw/rtl/audio_soft_limiter_core.sv
// Audio soft limiter, top level: front end, chain of divider cells, back end.
// Uses asl_pkg, asl_front, asl_div_cell and asl_finish.
//
// Usage:
//   s_ channel takes one sample a beat in s_tdata (sample_in, bits 31:0); the
//   low SAMPLE_BITS bits are the signed sample. m_ channel returns one beat per
//   input beat in m_tdata (sample_out, bits 31:0), sign-extended.
//   cfg channel writes full_scale (index 0) or threshold_level (index 1); other
//   indexes are ignored. cfg_ready is always high. Write only while idle.
//   The pipeline has one input stage, one cell per bit of the 62-bit
//   constant K in the divider chain, and two output stages.
//   Throughput is one beat per cycle while m_tready is high; every stage has its own valid bit, so
//   bubbles close up and input is taken while a result waits on m_tready.
//   When m_tready stays low the chain fills and s_tready drops after that.
//   Reset (aresetn low, synchronous) empties the pipeline and restores
//   full_scale = 32768 and threshold_level = 24576.
module audio_soft_limiter_core import asl_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DATA_BITS-1:0]    s_tdata,   // [31:0] sample_in
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DATA_BITS-1:0]    m_tdata,   // [31:0] sample_out
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]    cfg_data
);

    logic [FS_BITS-1:0]     full_scale;
    logic [K_BITS-1:0]      k_const;

    logic                   c_valid [K_BITS+1];
    logic                   c_ready [K_BITS+1];
    logic [SAMPLE_BITS-1:0] c_rem   [K_BITS+1];
    logic [Q_BITS-1:0]      c_quo   [K_BITS+1];
    logic [SAMPLE_BITS-1:0] c_mag   [K_BITS+1];
    asl_ctl_t               c_ctl   [K_BITS+1];

    asl_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .out_valid  (c_valid[0]),
        .out_ready  (c_ready[0]),
        .out_mag    (c_mag[0]),
        .out_ctl    (c_ctl[0]),
        .full_scale (full_scale),
        .k_const    (k_const)
    );

    assign c_rem[0] = '0;
    assign c_quo[0] = '0;

    for (genvar i = 0; i < K_BITS; i++) begin : g_cell
        asl_div_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .k_bit     (k_const[K_BITS-1-i]),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_rem    (c_rem[i]),
            .in_quo    (c_quo[i]),
            .in_mag    (c_mag[i]),
            .in_ctl    (c_ctl[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_quo   (c_quo[i+1]),
            .out_mag   (c_mag[i+1]),
            .out_ctl   (c_ctl[i+1])
        );
    end

    asl_finish #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .full_scale (full_scale),
        .in_valid   (c_valid[K_BITS]),
        .in_ready   (c_ready[K_BITS]),
        .in_rem     (c_rem[K_BITS]),
        .in_quo     (c_quo[K_BITS]),
        .in_mag     (c_mag[K_BITS]),
        .in_ctl     (c_ctl[K_BITS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule
